// ----- rtl/core/pcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix code bit packer: request and
// result payloads, request codes, table layout and controller interface.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int NUM_SYMBOLS  = 256;
  localparam int SYM_W        = 8;
  localparam int SYM_AW       = $clog2(NUM_SYMBOLS);
  localparam int ENTRY_W      = CODE_W + LEN_W;
  localparam int SHIFT_W      = BYTE_BITS + CODE_W;
  localparam int CNT_W        = 6;
  localparam int PEND_W       = 3;
  localparam int USED_W       = 4;

  // A code word holds at most CODE_W bits
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } pcbp_req_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic [USED_W-1:0]    used_bits;
    logic                 is_final;
    logic                 last_of_run;
  } pcbp_res_t;

  // Controller to datapath
  typedef struct packed {
    logic table_wr;
    logic table_rd;
    logic load;
    logic emit;
    logic commit;
    logic flush;
  } pcbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sym_ok;
    logic byte_ready;
    logic out_free;
  } pcbp_sts_t;

endpackage

// ----- rtl/core/pcbp_ram.sv -----
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pcbp_dp.sv -----
// ----------------------------------------------------------------------------
// pcbp_dp
// Datapath: code table, bit shifter, left-aligned pending-bit accumulator
// and the output register.
// ----------------------------------------------------------------------------
module pcbp_dp
  import pcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pcbp_req_t req,
  input  pcbp_cmd_t cmd,
  output pcbp_sts_t sts,
  output logic      res_valid,
  input  logic      res_stall,
  output pcbp_res_t res
);

  logic [ENTRY_W-1:0]   wr_entry;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [LEN_W-1:0]     wr_len;
  logic [CODE_W-1:0]    rd_word;
  logic [LEN_W-1:0]     rd_len;
  logic [2*CODE_W-1:0]  word_wide;
  logic [CODE_W-1:0]    word_left;
  logic [SHIFT_W-1:0]   merged;
  logic [SHIFT_W-1:0]   shift_reg;
  logic [CNT_W-1:0]     cnt;
  logic [BYTE_BITS-1:0] acc;
  logic [PEND_W-1:0]    pend;

  // Saturate the code length on a table write
  assign wr_len = (req.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                       : req.code_length;
  assign wr_entry = {wr_len, req.code_word};

  assign sts.sym_ok = ({1'b0, req.symbol} < (SYM_W + 1)'(NUM_SYMBOLS));

  pcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.table_wr && sts.sym_ok),
    .waddr (req.symbol[SYM_AW-1:0]),
    .wdata (wr_entry),
    .re    (cmd.table_rd),
    .raddr (req.symbol[SYM_AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_word = rd_entry[CODE_W-1:0];
  assign rd_len  = rd_entry[ENTRY_W-1:CODE_W];

  // Left-align the code bits, then place them after the pending bits
  assign word_wide = {{CODE_W{1'b0}}, rd_word} << (LEN_W'(CODE_W) - rd_len);
  assign word_left = word_wide[CODE_W-1:0];
  assign merged    = {acc, {CODE_W{1'b0}}} | ({word_left, {BYTE_BITS{1'b0}}} >> pend);

  assign sts.byte_ready = (cnt >= CNT_W'(BYTE_BITS));
  assign sts.out_free   = !res_valid || !res_stall;

  // Shifter, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      acc       <= '0;
      pend      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.emit || cmd.flush) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.load) begin
        shift_reg <= merged;
        cnt       <= CNT_W'(pend) + rd_len;
      end
      if (cmd.emit) begin
        res.out_byte    <= shift_reg[SHIFT_W-1 -: BYTE_BITS];
        res.used_bits   <= USED_W'(BYTE_BITS);
        res.is_final    <= 1'b0;
        res.last_of_run <= (cnt < CNT_W'(2*BYTE_BITS));
        shift_reg       <= shift_reg << BYTE_BITS;
        cnt             <= cnt - CNT_W'(BYTE_BITS);
      end
      if (cmd.commit) begin
        acc  <= shift_reg[SHIFT_W-1 -: BYTE_BITS];
        pend <= cnt[PEND_W-1:0];
      end
      if (cmd.flush) begin
        res.out_byte    <= acc;
        res.used_bits   <= USED_W'(pend);
        res.is_final    <= 1'b1;
        res.last_of_run <= 1'b1;
        acc             <= '0;
        pend            <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/pcbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcbp_ctrl
// Controller: accepts one request transaction at a time and sequences the
// table access, byte emission and accumulator update.
// ----------------------------------------------------------------------------
module pcbp_ctrl
  import pcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  pcbp_sts_t  sts,
  output pcbp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_WRITE: begin
              cmd.table_wr = 1'b1;
            end
            REQ_ENCODE: begin
              if (sts.sym_ok) begin
                cmd.table_rd = 1'b1;
                state_next   = ST_READ;
              end
            end
            REQ_FLUSH: begin
              state_next = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.load   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.byte_ready) begin
          cmd.emit = sts.out_free;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/prefix_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Prefix-code bit packer: code table writes, symbol encoding into bytes,
// and end-of-stream flush.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time. An encode reads the code
// table RAM through its registered read port, merges the code with the
// pending bits, passes each byte it completes (0 to 4) through the output
// register, and stores the leftover bits. A flush passes the pending bits
// through the output register. Stalls on the result side hold an encode
// or a flush until the output register is free. Bytes are packed most
// significant bit first; a flush byte carries the pending bits
// left-aligned and zero-padded, with used_bits giving their count.
module prefix_code_bit_packer
  import pcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  pcbp_req_t req,
  output logic      res_valid,
  input  logic      res_stall,
  output pcbp_res_t res
);

  pcbp_cmd_t cmd;
  pcbp_sts_t sts;

  pcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req.req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
